[sv/tvac_pkg.sv]
// Package for the tag-value appendage checker.
// Holds the beat, configuration and result types and the walk phase codes.
// No dependencies.
package tvac_pkg;

  localparam int unsigned PosWidth = 17;
  localparam logic [PosWidth-1:0] PosMax = '1;

  localparam int unsigned CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] RegAppendageBase  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegLengthOptional = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegWantedTag      = 2'd2;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TAG,
    PH_STOP
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic [7:0] appendage_base;
    logic       length_optional;
    logic [7:0] wanted_tag;
  } cfg_t;

  typedef struct packed {
    logic                status;
    logic [15:0]         appendage_size;
    logic                option_found;
    logic [PosWidth-1:0] value_offset;
    logic [7:0]          value_length;
  } result_t;

endpackage

[sv/tvac_if.sv]
// Channel interfaces of the tag-value appendage checker: message bytes,
// results and configuration writes. Widths are written out; no package is imported.
interface tvac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface tvac_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] appendage_size;
  logic        option_found;
  logic [16:0] value_offset;
  logic [7:0]  value_length;
  modport source (output valid, status, appendage_size, option_found, value_offset,
                  value_length, input ready);
  modport sink (input valid, status, appendage_size, option_found, value_offset,
                value_length, output ready);
endinterface

interface tvac_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/tvac_in_stage.sv]
// Input register of the tag-value appendage checker.
// Holds one message byte beat until the walker consumes it. Depends on tvac_pkg.
module tvac_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  tvac_in_if.sink       in_i,
  input  logic          take_i,
  output logic          valid_o,
  output tvac_pkg::beat_t beat_o
);
  import tvac_pkg::*;

  logic  valid_q, valid_d;
  beat_t beat_q;

  assign in_i.ready = !valid_q || take_i;
  assign valid_d    = (in_i.valid && in_i.ready) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      beat_q <= '{data_byte: in_i.data_byte, last_byte: in_i.last_byte};
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule

[sv/tvac_walker.sv]
// Message state and element walk of the tag-value appendage checker.
// Consumes one byte per take and forms the result on the last byte. Depends on tvac_pkg.
module tvac_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  tvac_pkg::beat_t   beat_i,
  input  tvac_pkg::cfg_t    cfg_i,
  output logic              result_valid_o,
  output tvac_pkg::result_t result_o
);
  import tvac_pkg::*;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [15:0]         decl_q, decl_d;
  logic [15:0]         elem_start_q, elem_start_d;
  phase_e              phase_q, phase_d;
  logic [7:0]          elem_len_q, elem_len_d;
  logic                broken_q, broken_d;
  logic                found_q, found_d;
  logic [PosWidth-1:0] found_offset_q, found_offset_d;
  logic [7:0]          found_len_q, found_len_d;

  logic [PosWidth-1:0] base_ext;
  logic [PosWidth-1:0] start;
  logic [PosWidth-1:0] rel;
  logic [15:0]         rem;
  logic [7:0]          b;
  logic [17:0]         size;
  logic [17:0]         base18;
  logic [17:0]         end18;

  assign b        = beat_i.data_byte;
  assign base_ext = {{(PosWidth-8){1'b0}}, cfg_i.appendage_base};
  assign start    = base_ext + PosWidth'(2);
  assign rel      = pos_q - start;
  assign rem      = decl_q - rel[15:0] - 16'd1;

  always_comb begin
    pos_d          = (pos_q == PosMax) ? pos_q : pos_q + PosWidth'(1);
    decl_d         = decl_q;
    elem_start_d   = elem_start_q;
    phase_d        = phase_q;
    elem_len_d     = elem_len_q;
    broken_d       = broken_q;
    found_d        = found_q;
    found_offset_d = found_offset_q;
    found_len_d    = found_len_q;
    if (pos_q == base_ext) begin
      decl_d = {b, 8'h00};
    end else if (pos_q == base_ext + PosWidth'(1)) begin
      decl_d       = {decl_q[15:8], b};
      elem_start_d = '0;
      phase_d      = PH_LEN;
    end else if (pos_q >= start && phase_q != PH_STOP && rel < {1'b0, decl_q}) begin
      case (phase_q)
        PH_LEN: begin
          if (rel[15:0] == elem_start_q) begin
            if (b == 8'd0 || {8'd0, b} > rem) begin
              broken_d = 1'b1;
              phase_d  = PH_STOP;
            end else begin
              elem_len_d = b;
              phase_d    = PH_TAG;
            end
          end
        end
        PH_TAG: begin
          if (rel == {1'b0, elem_start_q} + PosWidth'(1)) begin
            if (!found_q && b == cfg_i.wanted_tag) begin
              found_d        = 1'b1;
              found_offset_d = pos_q + PosWidth'(1);
              found_len_d    = elem_len_q - 8'd1;
            end
            elem_start_d = elem_start_q + 16'd1 + {8'd0, elem_len_q};
            phase_d      = PH_LEN;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign size   = {1'b0, pos_q} + 18'd1;
  assign base18 = {10'd0, cfg_i.appendage_base};
  assign end18  = base18 + 18'd2 + {2'd0, decl_d};

  always_comb begin
    result_o = '0;
    result_o.status = 1'b1;
    if (size < base18) begin
      result_o.status = 1'b1;
    end else if (size < base18 + 18'd2) begin
      result_o.status = !(cfg_i.length_optional && size == base18);
    end else if (size < end18) begin
      result_o.status = 1'b1;
    end else begin
      result_o.status         = broken_d;
      result_o.appendage_size = decl_d;
      result_o.option_found   = found_d;
      if (found_d) begin
        result_o.value_offset = found_offset_d;
        result_o.value_length = found_len_d;
      end
    end
  end

  assign result_valid_o = take_i && beat_i.last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      decl_q         <= '0;
      elem_start_q   <= '0;
      phase_q        <= PH_LEN;
      elem_len_q     <= '0;
      broken_q       <= 1'b0;
      found_q        <= 1'b0;
      found_offset_q <= '0;
      found_len_q    <= '0;
    end else if (take_i) begin
      if (beat_i.last_byte) begin
        pos_q          <= '0;
        decl_q         <= '0;
        elem_start_q   <= '0;
        phase_q        <= PH_LEN;
        elem_len_q     <= '0;
        broken_q       <= 1'b0;
        found_q        <= 1'b0;
        found_offset_q <= '0;
        found_len_q    <= '0;
      end else begin
        pos_q          <= pos_d;
        decl_q         <= decl_d;
        elem_start_q   <= elem_start_d;
        phase_q        <= phase_d;
        elem_len_q     <= elem_len_d;
        broken_q       <= broken_d;
        found_q        <= found_d;
        found_offset_q <= found_offset_d;
        found_len_q    <= found_len_d;
      end
    end
  end
endmodule

[sv/tvac_out_stage.sv]
// Result register of the tag-value appendage checker.
// Holds one result beat until the sink takes it. Depends on tvac_pkg.
module tvac_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  tvac_pkg::result_t result_i,
  output logic              free_o,
  tvac_out_if.source        out_o
);
  import tvac_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.status         = result_q.status;
  assign out_o.appendage_size = result_q.appendage_size;
  assign out_o.option_found   = result_q.option_found;
  assign out_o.value_offset   = result_q.value_offset;
  assign out_o.value_length   = result_q.value_length;
endmodule

[sv/tag_value_appendage_checker_top.sv]
// The checker takes one message byte per cycle with no gaps of its own while the
// output register can take a result: a byte is accepted into the input register and
// walked from there and, if it is the last byte, its result is loaded into the
// output register, from which the result beat is offered. A result waiting in the
// output register stalls the walk only while the sink holds ready low.
// Configuration writes are always ready and take effect at once; write them only
// between messages.
// Top level: instantiates tvac_in_stage, tvac_walker and tvac_out_stage.
// Depends on tvac_pkg and the channel interfaces in tvac_if.
module tag_value_appendage_checker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  tvac_in_if.sink    in_i,
  tvac_out_if.source out_o,
  tvac_cfg_if.sink   cfg_i
);
  import tvac_pkg::*;

  cfg_t    cfg_q;
  beat_t   beat;
  result_t result;
  logic    beat_valid;
  logic    out_free;
  logic    take;
  logic    result_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        RegAppendageBase:  cfg_q.appendage_base  <= cfg_i.data;
        RegLengthOptional: cfg_q.length_optional <= cfg_i.data[0];
        RegWantedTag:      cfg_q.wanted_tag      <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign take = beat_valid && out_free;

  tvac_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (beat_valid),
    .beat_o  (beat)
  );

  tvac_walker u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .beat_i         (beat),
    .cfg_i          (cfg_q),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  tvac_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (result_valid),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.option_found |-> out_o.value_offset == '0 && out_o.value_length == '0)
    else $error("Result without an option carries a nonzero position or size.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.option_found |->
      {8'd0, out_o.value_length} < out_o.appendage_size)
    else $error("Found option does not fit inside the appendage.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.option_found |->
      out_o.value_offset >= {9'd0, cfg_q.appendage_base} + 17'd4)
    else $error("Found option lies before the appendage.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid |-> take && out_free)
    else $error("Result formed while the output register was not free.");
endmodule

[tb/tag_value_appendage_checker_top_tb.sv]
// Self-checking testbench for tag_value_appendage_checker_top: drives message bytes
// and register writes, predicts each message verdict and compares every result beat.
// Depends on tvac_pkg, the channel interfaces in tvac_if and the checker RTL.
module tag_value_appendage_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tvac_pkg::*;

  localparam logic [CfgIndexWidth-1:0] RegUnused = 2'd3;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned LongHoldCycles = 300;

  class verdict_scoreboard;
    logic [7:0] base_off;
    logic optional_ok;
    logic [7:0] tag_sought;
    int unsigned position;
    int unsigned decl_len;
    int unsigned elem_start;
    int unsigned elem_len;
    int unsigned hit_offset;
    int unsigned hit_len;
    phase_e walk_state;
    bit broken;
    bit hit;
    result_t awaited[$];
    int unsigned failures;

    function new();
      base_off = '0;
      optional_ok = 1'b0;
      tag_sought = '0;
      failures = 0;
      restart();
    endfunction

    function void restart();
      position = 0;
      decl_len = 0;
      elem_start = 0;
      walk_state = PH_LEN;
      elem_len = 0;
      broken = 1'b0;
      hit = 1'b0;
      hit_offset = 0;
      hit_len = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void write_register(logic [CfgIndexWidth-1:0] idx, logic [7:0] val);
      case (idx)
        RegAppendageBase: base_off = val;
        RegLengthOptional: optional_ok = val[0];
        RegWantedTag: tag_sought = val;
        default: ;
      endcase
    endfunction

    function void walk(int unsigned p, int unsigned b);
      int unsigned start;
      int unsigned a;
      start = base_off + 32'd2;
      if (p < start || walk_state == PH_STOP) return;
      a = p - start;
      if (a >= decl_len) return;
      if (walk_state == PH_LEN) begin
        if (a != elem_start) return;
        if (b == 0 || b > decl_len - a - 1) begin
          broken = 1'b1;
          walk_state = PH_STOP;
          return;
        end
        elem_len = b;
        walk_state = PH_TAG;
      end else begin
        if (a != elem_start + 1) return;
        if (!hit && b == tag_sought) begin
          hit = 1'b1;
          hit_offset = (p + 1) & PosMax;
          hit_len = (elem_len - 1) & 32'hFF;
        end
        elem_start = (elem_start + 1 + elem_len) & 32'hFFFF;
        walk_state = PH_LEN;
      end
    endfunction

    function void absorb_byte(logic [7:0] data, logic last);
      int unsigned p;
      int unsigned b;
      int unsigned bs;
      int unsigned size;
      result_t r;
      p = position;
      b = data;
      bs = base_off;
      if (p == bs) begin
        decl_len = b << 8;
      end else if (p == bs + 1) begin
        decl_len = (decl_len & 32'hFF00) | b;
        elem_start = 0;
        walk_state = PH_LEN;
      end else begin
        walk(p, b);
      end
      position = (p < PosMax) ? p + 1 : PosMax;
      if (!last) return;
      size = p + 1;
      r = '0;
      r.status = 1'b1;
      if (size < bs) begin
        r.status = 1'b1;
      end else if (size < bs + 2) begin
        r.status = (optional_ok && size == bs) ? 1'b0 : 1'b1;
      end else if (size < bs + 2 + decl_len) begin
        r.status = 1'b1;
      end else begin
        r.status = broken;
        r.appendage_size = decl_len[15:0];
        r.option_found = hit;
        if (hit) begin
          r.value_offset = hit_offset[PosWidth-1:0];
          r.value_length = hit_len[7:0];
        end
      end
      awaited.push_back(r);
      restart();
    endfunction

    function string describe(result_t r);
      return $sformatf("status %0d length %0d found %0d offset %0d value_length %0d",
                       r.status, r.appendage_size, r.option_found, r.value_offset,
                       r.value_length);
    endfunction

    function void match_verdict(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10) $display("Unexpected result beat: %s", describe(got));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.appendage_size !== want.appendage_size ||
          got.option_found !== want.option_found || got.value_offset !== want.value_offset ||
          got.value_length !== want.value_length) begin
        failures++;
        if (failures <= 10) begin
          $display("Result mismatch: expected %s", describe(want));
          $display("                 actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tvac_in_if in_if ();
  tvac_out_if out_if ();
  tvac_cfg_if cfg_if ();

  tag_value_appendage_checker_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  verdict_scoreboard board = new();

  bit idling_on = 1'b1;
  bit hold_pending = 1'b0;
  logic [7:0] cur_base = '0;
  logic [7:0] cur_tag = '0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  logic [7:0] frame[$];
  logic [7:0] tlv[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin : watch
    result_t seen;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) board.write_register(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) board.absorb_byte(in_if.data_byte, in_if.last_byte);
      if (out_if.valid && out_if.ready) begin
        seen.status = out_if.status;
        seen.appendage_size = out_if.appendage_size;
        seen.option_found = out_if.option_found;
        seen.value_offset = out_if.value_offset;
        seen.value_length = out_if.value_length;
        board.match_verdict(seen);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idling_on || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The result side stalls on its own; a requested long hold lets the input back up.
  initial begin : result_sink
    int unsigned gap;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_beat(logic [7:0] d, logic l);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= d;
    in_if.last_byte <= l;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_beat(frame[i], i == frame.size() - 1);
    beats_sent += frame.size();
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic program_settings(logic [7:0] base, logic opt, logic [7:0] tag);
    cur_base = base;
    cur_tag = tag;
    write_reg(RegAppendageBase, base);
    write_reg(RegLengthOptional, {7'($urandom), opt});
    write_reg(RegWantedTag, tag);
    write_reg(RegUnused, 8'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic void add_element(int unsigned len, logic [7:0] tg);
    tlv.push_back(len[7:0]);
    tlv.push_back(tg);
    repeat (len - 1) tlv.push_back(8'($urandom));
  endfunction

  function automatic void fill_good_tlv();
    int unsigned count;
    int unsigned len;
    logic [7:0] tg;
    tlv.delete();
    count = $urandom_range(0, 4);
    repeat (count) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
      tg = ($urandom_range(0, 2) == 0) ? cur_tag : 8'($urandom);
      add_element(len, tg);
    end
  endfunction

  function automatic void compose_frame();
    int unsigned n;
    frame.delete();
    repeat (cur_base) frame.push_back(8'($urandom));
    n = tlv.size();
    frame.push_back(n[15:8]);
    frame.push_back(n[7:0]);
    foreach (tlv[i]) frame.push_back(tlv[i]);
  endfunction

  initial begin : stimulus
    int unsigned kind;
    int unsigned k;
    int unsigned cut;
    int unsigned phase_start;
    int unsigned rand_msgs;
    int unsigned roll;
    logic [7:0] tg;
    in_if.valid <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_settings(8'd0, 1'b0, 8'h00);
    frame = '{8'h5A};
    send_frame();
    frame = '{8'h00, 8'h00};
    send_frame();
    frame = '{8'h00, 8'h03, 8'h02, 8'h00, 8'hFF};
    send_frame();
    frame = '{8'h00, 8'h02, 8'h00, 8'h11};
    send_frame();
    frame = '{8'h00, 8'h02, 8'h05, 8'h00};
    send_frame();
    frame = '{8'h00, 8'h05, 8'h01, 8'h00};
    send_frame();
    frame = '{8'hFF, 8'hFF, 8'h01, 8'h02};
    send_frame();

    settle();
    program_settings(8'd4, 1'b1, 8'hFF);
    frame = '{8'h01, 8'h02, 8'h03};
    send_frame();
    frame = '{8'h01, 8'h02, 8'h03, 8'h04};
    send_frame();
    frame = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h00};
    send_frame();
    tlv.delete();
    add_element(255, 8'hFF);
    add_element(2, 8'h00);
    compose_frame();
    repeat (3) frame.push_back(8'($urandom));
    send_frame();
    tlv.delete();
    add_element(2, 8'hFF);
    tlv.push_back(8'h00);
    tlv.push_back(8'h33);
    compose_frame();
    send_frame();
    tlv.delete();
    add_element(3, 8'h10);
    add_element(1, 8'hFF);
    add_element(4, 8'hFF);
    compose_frame();
    send_frame();

    settle();
    program_settings(8'd4, 1'b0, 8'h00);
    frame = '{8'h01, 8'h02, 8'h03, 8'h04};
    send_frame();

    // Largest appendage base and a longest element ahead of the one that carries the
    // wanted tag, followed by a few bytes beyond the appendage.
    settle();
    program_settings(8'd255, 1'b1, 8'hA5);
    idling_on = 1'b0;
    tlv.delete();
    repeat (1) begin
      tg = 8'($urandom);
      if (tg == cur_tag) tg = ~tg;
      add_element(255, tg);
    end
    add_element(3, cur_tag);
    compose_frame();
    repeat (5) frame.push_back(8'($urandom));
    send_frame();
    idling_on = 1'b1;
    tlv.delete();
    compose_frame();
    void'(frame.pop_back());
    void'(frame.pop_back());
    send_frame();

    phase_start = beats_sent;
    rand_msgs = 0;
    roll = 0;
    while (beats_sent < 1550 || rand_msgs < 48) begin
      if (rand_msgs == 0 || beats_sent - phase_start >= 200) begin
        settle();
        roll = $urandom_range(0, 9);
        if (roll < 7) program_settings(8'($urandom_range(0, 8)), 1'($urandom),
                                       8'($urandom));
        else if (roll < 9) program_settings(8'($urandom_range(9, 40)), 1'($urandom),
                                            8'($urandom));
        else program_settings(8'($urandom_range(200, 255)), 1'($urandom), 8'($urandom));
        idling_on = ($urandom_range(0, 3) != 0);
        hold_pending = 1'b1;
        phase_start = beats_sent;
      end
      kind = $urandom_range(0, 99);
      fill_good_tlv();
      if (kind >= 70 && kind < 82) begin
        k = $urandom_range(1, 8);
        tlv.push_back(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(k, 255)));
        repeat (k - 1) tlv.push_back(8'($urandom));
      end else if (kind >= 82 && kind < 90) begin
        tlv.delete();
        repeat ($urandom_range(0, 24)) tlv.push_back(8'($urandom));
      end
      compose_frame();
      if (kind >= 90) begin
        frame[cur_base] = 8'($urandom);
        frame[cur_base + 1] = 8'($urandom);
      end
      if (kind >= 60 && kind < 70) begin
        cut = $urandom_range(1, frame.size() - 1);
        while (frame.size() > cut) void'(frame.pop_back());
      end else if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
      end
      send_frame();
      rand_msgs++;
      if ($urandom_range(0, 14) == 0) settle();
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
